// ===== sv/f32cs_pkg.sv =====
package f32cs_pkg;

  localparam logic [15:0] SUM_INIT = 16'hFFFF;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned HALF_W = 16;

  // input word: one message byte
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] expected_sum;
  } f32cs_in_t;

  // result word
  typedef struct packed {
    logic [31:0] checksum_value;
    logic        matches_res;
  } f32cs_out_t;

  // paired 16-bit word handed from front to back
  typedef struct packed {
    logic [15:0] word;
    logic        last;
    logic [31:0] expected;
  } f32cs_word_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic not_empty;
  } f32cs_q_st_t;

  // ones'-complement add with end-around carry; nonzero input never gives zero
  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'b0, s[16]};
  endfunction

endpackage

// ===== sv/f32cs_front.sv =====
module f32cs_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  f32cs_pkg::f32cs_in_t  in_data,
  input  f32cs_pkg::f32cs_q_st_t q_st,
  output logic                  push,
  output f32cs_pkg::f32cs_word_t push_word
);

  logic [7:0] held_r;
  logic       have_r;
  logic       acc;

  // accept whenever the queue has room
  assign in_ready = !q_st.full;
  assign acc      = in_valid && in_ready;

  // a word leaves once the pair completes or the message ends
  assign push = acc && (have_r || in_data.last_byte);

  always_comb begin
    push_word.last     = in_data.last_byte;
    push_word.expected = in_data.expected_sum;
    if (have_r) begin
      push_word.word = {held_r, in_data.data_byte};
    end else begin
      push_word.word = {in_data.data_byte, 8'h00};
    end
  end

  // high byte holding
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      held_r <= '0;
    end else if (acc) begin
      if (have_r || in_data.last_byte) begin
        have_r <= 1'b0;
      end else begin
        have_r <= 1'b1;
        held_r <= in_data.data_byte;
      end
    end
  end

endmodule

// ===== sv/f32cs_fifo.sv =====
module f32cs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  f32cs_pkg::f32cs_word_t push_word,
  input  logic                   pop,
  output f32cs_pkg::f32cs_word_t head_word,
  output f32cs_pkg::f32cs_q_st_t q_st
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  f32cs_pkg::f32cs_word_t mem_r [DEPTH];
  logic [AW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;

  assign q_st.full      = (cnt_r == CW'(DEPTH));
  assign q_st.not_empty = (cnt_r != '0);
  assign head_word      = mem_r[rd_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_word;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== sv/f32cs_back.sv =====
module f32cs_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  f32cs_pkg::f32cs_word_t head_word,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output f32cs_pkg::f32cs_out_t  out_data
);

  logic [15:0] first_r;
  logic [15:0] second_r;
  logic        a_valid_r;
  logic [15:0] a_first_r;
  logic        a_last_r;
  logic        a_lo_match_r;
  logic [15:0] a_exp_hi_r;
  logic        out_valid_r;
  f32cs_pkg::f32cs_out_t out_r;

  logic [15:0] first_nxt;
  logic [15:0] second_nxt;
  logic        out_free;
  logic        adv_b;

  assign out_free   = !out_valid_r || out_ready;
  assign adv_b      = a_valid_r && (!a_last_r || out_free);
  assign pop        = q_valid && (!a_valid_r || adv_b);
  assign first_nxt  = f32cs_pkg::ones_add(first_r, head_word.word);
  assign second_nxt = f32cs_pkg::ones_add(second_r, a_first_r);

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stage a: first sum, low half compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r   <= f32cs_pkg::SUM_INIT;
      a_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        a_valid_r <= 1'b1;
        first_r   <= head_word.last ? f32cs_pkg::SUM_INIT : first_nxt;
      end else if (adv_b) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_first_r    <= first_nxt;
      a_last_r     <= head_word.last;
      a_lo_match_r <= (first_nxt == head_word.expected[15:0]);
      a_exp_hi_r   <= head_word.expected[31:16];
    end
  end

  // stage b: second sum and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_r    <= f32cs_pkg::SUM_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_b) begin
        second_r <= a_last_r ? f32cs_pkg::SUM_INIT : second_nxt;
      end
      if (adv_b && a_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_last_r) begin
      out_r.checksum_value <= {second_nxt, a_first_r};
      out_r.matches_res    <= a_lo_match_r && (second_nxt == a_exp_hi_r);
    end
  end

endmodule

// ===== sv/fletcher32_checksum_stream_unit.sv =====
// channel | ports                      | payload
// --------+----------------------------+---------------------------------------
// input   | in_valid, in_ready         | in_data: data_byte, last_byte, expected
// result  | out_valid, out_ready       | out_data: checksum_value, matches_res
//
// One byte per cycle while the queue has room. A message's last word goes from
// the queue to stage a, then sets out_valid once the result register is free.
// The front pairs bytes into words, the queue (QUEUE_DEPTH entries) decouples it
// from the back, where one stage updates the first sum and the next the second.
// in_ready drops only when the queue is full; a held result does not stall the
// back for words that are not last. Reset (synchronous) empties all stages and
// loads both sums with 0xFFFF.
module fletcher32_checksum_stream_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  f32cs_pkg::f32cs_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output f32cs_pkg::f32cs_out_t out_data
);

  f32cs_pkg::f32cs_q_st_t q_st;
  f32cs_pkg::f32cs_word_t push_word;
  f32cs_pkg::f32cs_word_t head_word;
  logic push;
  logic pop;

  // byte pairing
  f32cs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_st      (q_st),
    .push      (push),
    .push_word (push_word)
  );

  // word queue
  f32cs_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_st      (q_st)
  );

  // accumulators
  f32cs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_st.not_empty),
    .head_word (head_word),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // end-around carry never leaves a zero sum
  a_nonzero_sums: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.checksum_value[15:0] != 16'h0000) &&
                  (out_data.checksum_value[31:16] != 16'h0000))
    else $error("zero half in checksum result");

  // a last word always lands in the queue
  a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_byte |=> q_st.not_empty)
    else $error("last word not queued");

  // queue fills only through an accepted word
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("queue filled without input");

endmodule
